### src/irbd_pkg.sv
// irbd_pkg: shared types, codes and constants of the interleaved rle bitmap decoder
// no dependencies; used by the front, back and top modules and by the bench
`default_nettype none
package irbd_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int CFG_W          = 13;
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd64;

    // register indexes (paddr[2])
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // input commands
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_BAD   = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OVERRUN = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_TRUNC   = 3'd3;
    localparam logic [2:0] ST_MISUSE  = 3'd4;

    // order codes
    localparam logic [3:0] OP_FILL     = 4'd0;
    localparam logic [3:0] OP_MIX      = 4'd1;
    localparam logic [3:0] OP_FOM      = 4'd2;
    localparam logic [3:0] OP_COLOR    = 4'd3;
    localparam logic [3:0] OP_COPY     = 4'd4;
    localparam logic [3:0] OP_MIX_SET  = 4'd6;
    localparam logic [3:0] OP_FOM_SET  = 4'd7;
    localparam logic [3:0] OP_BICOLOR  = 4'd8;
    localparam logic [3:0] OP_FOM_M1   = 4'd9;
    localparam logic [3:0] OP_FOM_M2   = 4'd10;
    localparam logic [3:0] OP_SPECIAL  = 4'd11;
    localparam logic [3:0] OP_WHITE    = 4'd13;
    localparam logic [3:0] OP_BLACK    = 4'd14;
    localparam logic [4:0] OP_NONE     = 5'd16;
    localparam logic [3:0] OP_SET_DIFF = 4'd5;

    localparam logic [2:0] MASK_M1 = 3'd3;
    localparam logic [2:0] MASK_M2 = 3'd5;

    typedef enum logic [8:0] {
        PH_HEADER = 9'b000000001,
        PH_EXT    = 9'b000000010,
        PH_CNT_LO = 9'b000000100,
        PH_CNT_HI = 9'b000001000,
        PH_COL1   = 9'b000010000,
        PH_COL2   = 9'b000100000,
        PH_MIX    = 9'b001000000,
        PH_BODY   = 9'b010000000,
        PH_DONE   = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic        pixel_valid;
        logic [7:0]  pixel_value;
        logic [11:0] pixel_column;
        logic [11:0] pixel_row;
        logic        wants_byte;
        logic        finished;
        logic [2:0]  status;
    } result_t;

    // configuration in effect after this cycle, with a restart strobe
    typedef struct packed {
        logic             restart;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } cfg_t;

endpackage
`default_nettype wire

### src/irbd_ifs.sv
// irbd_in_if / irbd_out_if: valid-ready channels for input items and result items
// no dependencies
`default_nettype none
interface irbd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output command, output data_byte, output last_byte,
                    input ready);
    modport sink (input valid, input command, input data_byte, input last_byte,
                  output ready);
endinterface

interface irbd_out_if;
    logic        valid;
    logic        ready;
    logic        pixel_valid;
    logic [7:0]  pixel_value;
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
    logic        wants_byte;
    logic        finished;
    logic [2:0]  status;

    modport source (output valid, output pixel_valid, output pixel_value,
                    output pixel_column, output pixel_row, output wants_byte,
                    output finished, output status, input ready);
    modport sink (input valid, input pixel_valid, input pixel_value,
                  input pixel_column, input pixel_row, input wants_byte,
                  input finished, input status, output ready);
endinterface
`default_nettype wire

### src/irbd_ram.sv
// irbd_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module irbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### src/irbd_front.sv
// irbd_front: two-entry queue that accepts input transactions ahead of the decoder
// depends on irbd_pkg and irbd_ifs
`default_nettype none
module irbd_front (
    input  wire logic clk,
    input  wire logic rst_n,
    irbd_in_if.sink   in_ch,
    irbd_in_if.source q_ch
);
    import irbd_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    item_t      head;

    assign in_ch.ready = (count_reg != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign pop  = q_ch.valid && q_ch.ready;

    assign head = entry_reg[rd_ptr_reg];
    assign q_ch.valid     = (count_reg != 2'd0);
    assign q_ch.command   = head.command;
    assign q_ch.data_byte = head.data_byte;
    assign q_ch.last_byte = head.last_byte;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{in_ch.command, in_ch.data_byte, in_ch.last_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule
`default_nettype wire

### src/irbd_back.sv
// irbd_back: decoder state, pixel generation, previous-row ram and result register
// depends on irbd_pkg, irbd_ifs and irbd_ram
`default_nettype none
module irbd_back #(
    parameter int MAX_WIDTH  = irbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = irbd_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire irbd_pkg::cfg_t cfg,
    irbd_in_if.sink            q_ch,
    irbd_out_if.source         res_ch
);
    import irbd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    // effective size after reset, clamped like a written value
    localparam int RST_W = (32'(CFG_RESET) > MAX_WIDTH) ? MAX_WIDTH : 32'(CFG_RESET);
    localparam int RST_H = (32'(CFG_RESET) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(CFG_RESET);

    function automatic logic needs_byte(input logic [3:0] op, input logic [2:0] fx,
                                        input logic [7:0] mb);
        return (op == OP_COPY) ||
               (op == OP_FOM && fx == 3'd0 && (mb == 8'h00 || mb == 8'h80));
    endfunction

    function automatic logic wants_of(input phase_t ph, input logic [3:0] op,
                                      input logic [2:0] fx, input logic [7:0] mb);
        if (ph == PH_DONE)
        begin
            return 1'b0;
        end
        if (ph == PH_BODY)
        begin
            return needs_byte(op, fx, mb);
        end
        return 1'b1;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] rows_reg, rows_next;
    logic        first_reg, first_next;
    logic [3:0]  op_reg, op_next;
    logic [4:0]  pop_reg, pop_next;
    logic [16:0] run_reg, run_next;
    logic [7:0]  c1_reg, c1_next, c2_reg, c2_next, mix_reg, mix_next;
    logic [7:0]  fmask_reg, fmask_next, mbit_reg, mbit_next;
    logic [2:0]  fixed_reg, fixed_next;
    logic        ins_reg, ins_next, tog_reg, tog_next, ended_reg, ended_next;

    result_t     out_reg, res;
    logic        out_valid_reg;
    logic        take;

    logic [CW-1:0] eff_w;
    logic [RW-1:0] eff_h;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, ram_q;
    logic          byp_reg;
    logic [7:0]    byp_data_reg;
    logic [7:0]    prev_mem;

    assign take = q_ch.valid && (!out_valid_reg || res_ch.ready);
    assign q_ch.ready = !out_valid_reg || res_ch.ready;

    always_comb
    begin
        if (cfg.width == '0)
        begin
            eff_w = CW'(1);
        end
        else if (32'(cfg.width) > MAX_WIDTH)
        begin
            eff_w = CW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = CW'(cfg.width);
        end
        if (32'(cfg.height) > MAX_HEIGHT)
        begin
            eff_h = RW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = RW'(cfg.height);
        end
    end

    assign prev_mem = byp_reg ? byp_data_reg : ram_q;

    always_comb
    begin
        logic          misuse, do_pix, after_cnt, enter;
        logic [7:0]    pbyte, v, prev, cnt;
        logic [3:0]    hi;
        logic [AW-1:0] x;

        phase_next = phase_reg;
        col_next   = col_reg;
        rows_next  = rows_reg;
        first_next = first_reg;
        op_next    = op_reg;
        pop_next   = pop_reg;
        run_next   = run_reg;
        c1_next    = c1_reg;
        c2_next    = c2_reg;
        mix_next   = mix_reg;
        fmask_next = fmask_reg;
        mbit_next  = mbit_reg;
        fixed_next = fixed_reg;
        ins_next   = ins_reg;
        tog_next   = tog_reg;
        ended_next = ended_reg;
        res        = '0;
        we         = 1'b0;
        waddr      = '0;
        wdata      = 8'h00;
        misuse     = 1'b0;
        do_pix     = 1'b0;
        after_cnt  = 1'b0;
        enter      = 1'b0;
        pbyte      = 8'h00;
        v          = 8'h00;
        prev       = 8'h00;
        cnt        = 8'h00;
        hi         = q_ch.data_byte[7:4];
        x          = '0;

        if (cfg.restart || (take && q_ch.command == CMD_START))
        begin
            col_next   = eff_w;
            rows_next  = eff_h;
            first_next = 1'b1;
            phase_next = PH_HEADER;
            op_next    = OP_FILL;
            pop_next   = OP_NONE;
            run_next   = '0;
            c1_next    = 8'h00;
            c2_next    = 8'h00;
            mix_next   = 8'hff;
            fmask_next = 8'h00;
            mbit_next  = 8'h00;
            fixed_next = 3'd0;
            ins_next   = 1'b0;
            tog_next   = 1'b0;
            ended_next = 1'b0;
        end
        else if (take)
        begin
            misuse = (q_ch.command == CMD_BAD) || (phase_reg == PH_DONE) ||
                     (wants_of(phase_reg, op_reg, fixed_reg, mbit_reg) !=
                      (q_ch.command == CMD_BYTE));
            if (misuse)
            begin
                res.status = ST_MISUSE;
            end
            else if (q_ch.command == CMD_TICK)
            begin
                do_pix = 1'b1;
            end
            else
            begin
                if (q_ch.last_byte)
                begin
                    ended_next = 1'b1;
                end
                case (phase_reg)
                    PH_HEADER:
                    begin
                        fixed_next = 3'd0;
                        if (hi >= 4'hc && hi <= 4'he)
                        begin
                            op_next = hi - 4'd6;
                            cnt     = {4'h0, q_ch.data_byte[3:0]};
                        end
                        else if (hi != 4'hf)
                        begin
                            op_next = {1'b0, hi[3:1]};
                            cnt     = {3'b000, q_ch.data_byte[4:0]};
                        end
                        if (hi == 4'hf)
                        begin
                            op_next = q_ch.data_byte[3:0];
                            if (op_next < OP_FOM_M1)
                            begin
                                run_next   = '0;
                                phase_next = PH_CNT_LO;
                            end
                            else
                            begin
                                run_next  = (op_next < OP_SPECIAL) ? 17'd8 : 17'd1;
                                after_cnt = 1'b1;
                            end
                        end
                        else if (cnt == 8'h00)
                        begin
                            phase_next = PH_EXT;
                        end
                        else
                        begin
                            if (op_next == OP_FOM || op_next == OP_FOM_SET)
                            begin
                                cnt = cnt << 3;
                            end
                            run_next  = {9'h000, cnt};
                            after_cnt = 1'b1;
                        end
                    end
                    PH_EXT:
                    begin
                        if (op_reg == OP_FOM || op_reg == OP_FOM_SET)
                        begin
                            run_next = {9'h000, q_ch.data_byte} + 17'd1;
                        end
                        else if (op_reg >= OP_MIX_SET)
                        begin
                            run_next = {9'h000, q_ch.data_byte} + 17'd16;
                        end
                        else
                        begin
                            run_next = {9'h000, q_ch.data_byte} + 17'd32;
                        end
                        after_cnt = 1'b1;
                    end
                    PH_CNT_LO:
                    begin
                        run_next   = {9'h000, q_ch.data_byte};
                        phase_next = PH_CNT_HI;
                    end
                    PH_CNT_HI:
                    begin
                        run_next  = run_reg | {1'b0, q_ch.data_byte, 8'h00};
                        after_cnt = 1'b1;
                    end
                    PH_COL1:
                    begin
                        c1_next    = q_ch.data_byte;
                        phase_next = PH_COL2;
                    end
                    PH_COL2:
                    begin
                        c2_next = q_ch.data_byte;
                        enter   = 1'b1;
                    end
                    PH_MIX:
                    begin
                        mix_next = q_ch.data_byte;
                        op_next  = op_reg - OP_SET_DIFF;
                        enter    = 1'b1;
                    end
                    default:
                    begin
                        do_pix = 1'b1;
                        pbyte  = q_ch.data_byte;
                    end
                endcase
            end

            if (after_cnt)
            begin
                case (op_next)
                    OP_FILL:
                    begin
                        if (pop_reg == {1'b0, OP_FILL} && !(col_reg == eff_w && first_reg))
                        begin
                            ins_next = 1'b1;
                        end
                        enter = 1'b1;
                    end
                    OP_BICOLOR: phase_next = PH_COL1;
                    OP_COLOR:   phase_next = PH_COL2;
                    OP_MIX_SET, OP_FOM_SET: phase_next = PH_MIX;
                    OP_FOM_M1, OP_FOM_M2:
                    begin
                        fixed_next = (op_next == OP_FOM_M1) ? MASK_M1 : MASK_M2;
                        fmask_next = {5'b00000, fixed_next};
                        op_next    = OP_FOM;
                        enter      = 1'b1;
                    end
                    default: enter = 1'b1;
                endcase
            end

            if (enter)
            begin
                pop_next   = {1'b0, op_next};
                mbit_next  = 8'h00;
                phase_next = PH_BODY;
            end

            if (do_pix)
            begin
                if (col_next >= eff_w)
                begin
                    if (rows_next < eff_h)
                    begin
                        first_next = 1'b0;
                    end
                    col_next = '0;
                    if (rows_next != '0)
                    begin
                        rows_next = rows_next - RW'(1);
                    end
                end
                x    = col_next[AW-1:0];
                prev = first_next ? 8'h00 : prev_mem;
                case (op_next)
                    OP_FILL:
                    begin
                        if (ins_next)
                        begin
                            v        = prev ^ mix_next;
                            ins_next = 1'b0;
                        end
                        else
                        begin
                            v = prev;
                        end
                    end
                    OP_MIX: v = prev ^ mix_next;
                    OP_FOM:
                    begin
                        mbit_next = mbit_next << 1;
                        if (mbit_next == 8'h00)
                        begin
                            fmask_next = (fixed_next != 3'd0) ? {5'b00000, fixed_next} : pbyte;
                            mbit_next  = 8'h01;
                        end
                        v = ((fmask_next & mbit_next) != 8'h00) ? (prev ^ mix_next) : prev;
                    end
                    OP_COLOR:   v = c2_next;
                    OP_COPY:    v = pbyte;
                    OP_BICOLOR: v = tog_next ? c2_next : c1_next;
                    OP_WHITE:   v = 8'hff;
                    default:    v = 8'h00;
                endcase
                if (op_next == OP_BICOLOR)
                begin
                    if (tog_next)
                    begin
                        tog_next = 1'b0;
                        run_next = run_next - 17'd1;
                    end
                    else
                    begin
                        tog_next = 1'b1;
                    end
                end
                else if (run_next != '0)
                begin
                    run_next = run_next - 17'd1;
                end
                we                = 1'b1;
                waddr             = x;
                wdata             = v;
                res.pixel_valid   = 1'b1;
                res.pixel_value   = v;
                res.pixel_column  = 12'(32'(x));
                res.pixel_row     = 12'(32'(rows_next));
                col_next          = CW'(32'(x) + 1);
            end

            if (!misuse)
            begin
                // settle the decoder after the step
                if (phase_next == PH_BODY && run_next == '0)
                begin
                    phase_next = PH_HEADER;
                end
                if (phase_next == PH_BODY)
                begin
                    if (col_next >= eff_w && rows_next == '0)
                    begin
                        phase_next = PH_DONE;
                        res.status = ST_OVERRUN;
                    end
                    else if (!(op_next <= OP_COPY || op_next == OP_BICOLOR ||
                               op_next == OP_WHITE || op_next == OP_BLACK))
                    begin
                        phase_next = PH_DONE;
                        res.status = ST_UNKNOWN;
                    end
                    else if (needs_byte(op_next, fixed_next, mbit_next) && ended_next)
                    begin
                        phase_next = PH_DONE;
                        res.status = ST_TRUNC;
                    end
                end
                else if (phase_next != PH_DONE && ended_next)
                begin
                    res.status = (phase_next == PH_HEADER) ? ST_OK : ST_TRUNC;
                    phase_next = PH_DONE;
                end
            end
        end

        res.wants_byte = wants_of(phase_next, op_next, fixed_next, mbit_next);
        res.finished   = (phase_next == PH_DONE);

        // prefetch the reference pixel for the next column
        if (col_next >= eff_w)
        begin
            raddr = '0;
        end
        else
        begin
            raddr = col_next[AW-1:0];
        end
    end

    irbd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_q)
    );

    assign res_ch.valid        = out_valid_reg;
    assign res_ch.pixel_valid  = out_reg.pixel_valid;
    assign res_ch.pixel_value  = out_reg.pixel_value;
    assign res_ch.pixel_column = out_reg.pixel_column;
    assign res_ch.pixel_row    = out_reg.pixel_row;
    assign res_ch.wants_byte   = out_reg.wants_byte;
    assign res_ch.finished     = out_reg.finished;
    assign res_ch.status       = out_reg.status;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= res;
        end
        byp_reg      <= we && (waddr == raddr);
        byp_data_reg <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HEADER;
            col_reg       <= CW'(RST_W);
            rows_reg      <= RW'(RST_H);
            first_reg     <= 1'b1;
            op_reg        <= OP_FILL;
            pop_reg       <= OP_NONE;
            run_reg       <= '0;
            c1_reg        <= 8'h00;
            c2_reg        <= 8'h00;
            mix_reg       <= 8'hff;
            fmask_reg     <= 8'h00;
            mbit_reg      <= 8'h00;
            fixed_reg     <= 3'd0;
            ins_reg       <= 1'b0;
            tog_reg       <= 1'b0;
            ended_reg     <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            phase_reg <= phase_next;
            col_reg   <= col_next;
            rows_reg  <= rows_next;
            first_reg <= first_next;
            op_reg    <= op_next;
            pop_reg   <= pop_next;
            run_reg   <= run_next;
            c1_reg    <= c1_next;
            c2_reg    <= c2_next;
            mix_reg   <= mix_next;
            fmask_reg <= fmask_next;
            mbit_reg  <= mbit_next;
            fixed_reg <= fixed_next;
            ins_reg   <= ins_next;
            tog_reg   <= tog_next;
            ended_reg <= ended_next;
        end
    end
endmodule
`default_nettype wire

### src/interleaved_rle_bitmap_decoder.sv
// channel     dir  handshake      payload
// in_stream   in   valid/ready    command, data_byte, last_byte
// out_stream  out  valid/ready    pixel_valid .. status, one result per input transaction
// apb         in   psel/penable   image_width at 0x0, image_height at 0x4
//
// one input transaction per clock while the output side accepts; its result is offered
// after passing the front queue and then the output register of the decoder.
// the decoder updates its state combinationally per item and fetches the row-above
// pixel ahead from the row ram. a two-entry queue in front lets input and output stall
// independently. reset loads 64 x 64 and the header phase; the row ram is not cleared.
`default_nettype none
module interleaved_rle_bitmap_decoder #(
    parameter int MAX_WIDTH  = irbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = irbd_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    irbd_in_if.sink          in_stream,
    irbd_out_if.source       out_stream
);
    import irbd_pkg::*;

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic             wr_en;
    cfg_t             cfg;

    irbd_in_if q_ch ();

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HEIGHT) ? {19'h00000, height_reg} : {19'h00000, width_reg};

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en && paddr[2] == REG_WIDTH)
        begin
            width_next = pwdata[CFG_W-1:0];
        end
        if (wr_en && paddr[2] == REG_HEIGHT)
        begin
            height_next = pwdata[CFG_W-1:0];
        end
        cfg.restart = wr_en;
        cfg.width   = width_next;
        cfg.height  = height_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_RESET;
            height_reg <= CFG_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    irbd_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_stream),
        .q_ch  (q_ch.source)
    );

    irbd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .q_ch   (q_ch.sink),
        .res_ch (out_stream)
    );
endmodule
`default_nettype wire

### sim/tb_top.sv
// tb_top: self-checking bench for interleaved_rle_bitmap_decoder, with an in-bench
// decoder predictor, random handshake gaps and apb register writes
// depends on irbd_pkg, irbd_in_if / irbd_out_if and the decoder rtl
`default_nettype none

module tb_top;
    import irbd_pkg::*;

class rle_scoreboard;
    result_t     pending_results[$];
    int unsigned mismatches;
    int unsigned img_w, img_h, col_pos, rows_left, run_left;
    logic [7:0]  row_mem [4096];
    phase_t      phase;
    logic [3:0]  cur_op;
    logic [4:0]  prev_op;
    logic [7:0]  colour1, colour2, mix_val, fmask, mbit;
    logic [2:0]  fixed;
    bit          first_row, mix_pending, bic_toggle, ended;

    function new();
        img_w = 64;
        img_h = 64;
        mismatches = 0;
        foreach (row_mem[i]) row_mem[i] = 8'h00;
        restart();
    endfunction

    function int unsigned eff_w();
        if (img_w == 0) return 1;
        if (img_w > 4096) return 4096;
        return img_w;
    endfunction

    function int unsigned eff_h();
        if (img_h > 4096) return 4096;
        return img_h;
    endfunction

    function void restart();
        col_pos = eff_w();
        rows_left = eff_h();
        first_row = 1;
        phase = PH_HEADER;
        cur_op = OP_FILL;
        prev_op = OP_NONE;
        run_left = 0;
        colour1 = 0;
        colour2 = 0;
        mix_val = 8'hff;
        fmask = 0;
        mbit = 0;
        fixed = 0;
        mix_pending = 0;
        bic_toggle = 0;
        ended = 0;
    endfunction

    function void configure(logic idx, logic [31:0] val);
        if (idx == REG_WIDTH) img_w = val & 32'h1fff;
        else img_h = val & 32'h1fff;
        restart();
    endfunction

    function bit needs_byte();
        if (cur_op == OP_COPY) return 1;
        return cur_op == OP_FOM && fixed == 0 && (mbit == 8'h00 || mbit == 8'h80);
    endfunction

    function bit wants_byte();
        if (phase == PH_DONE) return 0;
        if (phase == PH_BODY) return needs_byte();
        return 1;
    endfunction

    function bit known_op(logic [3:0] op);
        return op <= OP_COPY || op == OP_BICOLOR || op == OP_WHITE || op == OP_BLACK;
    endfunction

    function void enter_body();
        prev_op = {1'b0, cur_op};
        mbit = 0;
        phase = PH_BODY;
    endfunction

    function void after_count();
        case (cur_op)
            OP_FILL:
            begin
                // back-to-back fills get one mix pixel, except at the very start
                if (prev_op == {1'b0, OP_FILL} && !(col_pos == eff_w() && first_row))
                    mix_pending = 1;
                enter_body();
            end
            OP_BICOLOR: phase = PH_COL1;
            OP_COLOR: phase = PH_COL2;
            OP_MIX_SET, OP_FOM_SET: phase = PH_MIX;
            OP_FOM_M1, OP_FOM_M2:
            begin
                fixed = (cur_op == OP_FOM_M1) ? MASK_M1 : MASK_M2;
                fmask = {5'b0, fixed};
                cur_op = OP_FOM;
                enter_body();
            end
            default: enter_body();
        endcase
    endfunction

    function void decode_header(logic [7:0] code);
        logic [3:0] hi;
        int unsigned cnt;
        hi = code[7:4];
        fixed = 0;
        if (hi >= 4'hc && hi <= 4'he) begin
            cur_op = hi - 4'd6;
            cnt = code[3:0];
        end else if (hi == 4'hf) begin
            cur_op = code[3:0];
            if (cur_op < OP_FOM_M1) begin
                run_left = 0;
                phase = PH_CNT_LO;
                return;
            end
            run_left = (cur_op < OP_SPECIAL) ? 8 : 1;
            after_count();
            return;
        end else begin
            cur_op = {1'b0, hi[3:1]};
            cnt = code[4:0];
        end
        if (cnt == 0) begin
            phase = PH_EXT;
            return;
        end
        if (cur_op == OP_FOM || cur_op == OP_FOM_SET) cnt = cnt << 3;
        run_left = cnt;
        after_count();
    endfunction

    function logic [7:0] emit_pixel(logic [7:0] b, output int unsigned col,
                                    output int unsigned row);
        int unsigned x;
        logic [7:0] above, v;
        if (col_pos >= eff_w()) begin
            if (rows_left < eff_h()) first_row = 0;
            col_pos = 0;
            if (rows_left > 0) rows_left--;
        end
        x = (col_pos >= 4096) ? 4095 : col_pos;
        above = first_row ? 8'h00 : row_mem[x];
        case (cur_op)
            OP_FILL:
            begin
                v = mix_pending ? (above ^ mix_val) : above;
                mix_pending = 0;
            end
            OP_MIX: v = above ^ mix_val;
            OP_FOM:
            begin
                mbit = mbit << 1;
                if (mbit == 0) begin
                    fmask = (fixed != 0) ? {5'b0, fixed} : b;
                    mbit = 8'h01;
                end
                v = ((fmask & mbit) != 0) ? (above ^ mix_val) : above;
            end
            OP_COLOR: v = colour2;
            OP_COPY: v = b;
            OP_BICOLOR: v = bic_toggle ? colour2 : colour1;
            OP_WHITE: v = 8'hff;
            default: v = 8'h00;
        endcase
        if (cur_op == OP_BICOLOR) begin
            if (bic_toggle) begin
                bic_toggle = 0;
                run_left--;
            end else begin
                bic_toggle = 1;
            end
        end else if (run_left > 0) begin
            run_left--;
        end
        row_mem[x] = v;
        col = x;
        row = rows_left;
        col_pos = x + 1;
        return v;
    endfunction

    function logic [2:0] settle();
        if (phase == PH_BODY && run_left == 0) phase = PH_HEADER;
        if (phase == PH_DONE) return ST_OK;
        if (phase == PH_BODY) begin
            if (col_pos >= eff_w() && rows_left == 0) begin
                phase = PH_DONE;
                return ST_OVERRUN;
            end
            if (!known_op(cur_op)) begin
                phase = PH_DONE;
                return ST_UNKNOWN;
            end
            if (needs_byte() && ended) begin
                phase = PH_DONE;
                return ST_TRUNC;
            end
            return ST_OK;
        end
        if (ended) begin
            logic [2:0] st;
            st = (phase == PH_HEADER) ? ST_OK : ST_TRUNC;
            phase = PH_DONE;
            return st;
        end
        return ST_OK;
    endfunction

    // predicts the result of one accepted input transaction, returns its status
    function logic [2:0] note_input(item_t it);
        result_t r;
        int unsigned col, row;
        bit fom;
        r = '0;
        col = 0;
        row = 0;
        if (it.command == CMD_START) begin
            restart();
        end else if (it.command == CMD_BAD || phase == PH_DONE ||
                     wants_byte() != (it.command == CMD_BYTE)) begin
            r.status = ST_MISUSE;
        end else if (it.command == CMD_TICK) begin
            r.pixel_value = emit_pixel(8'h00, col, row);
            r.pixel_valid = 1;
            r.status = settle();
        end else begin
            if (it.last_byte) ended = 1;
            case (phase)
                PH_HEADER: decode_header(it.data_byte);
                PH_EXT:
                begin
                    fom = cur_op == OP_FOM || cur_op == OP_FOM_SET;
                    run_left = it.data_byte + (fom ? 1 : (cur_op >= OP_MIX_SET ? 16 : 32));
                    after_count();
                end
                PH_CNT_LO:
                begin
                    run_left = it.data_byte;
                    phase = PH_CNT_HI;
                end
                PH_CNT_HI:
                begin
                    run_left = run_left | (it.data_byte << 8);
                    after_count();
                end
                PH_COL1:
                begin
                    colour1 = it.data_byte;
                    phase = PH_COL2;
                end
                PH_COL2:
                begin
                    colour2 = it.data_byte;
                    enter_body();
                end
                PH_MIX:
                begin
                    mix_val = it.data_byte;
                    cur_op = cur_op - OP_SET_DIFF;
                    enter_body();
                end
                default:
                begin
                    r.pixel_value = emit_pixel(it.data_byte, col, row);
                    r.pixel_valid = 1;
                end
            endcase
            r.status = settle();
        end
        r.pixel_column = col[11:0];
        r.pixel_row = row[11:0];
        r.wants_byte = wants_byte();
        r.finished = phase == PH_DONE;
        pending_results.push_back(r);
        return r.status;
    endfunction

    function void check_result(result_t got);
        result_t exp;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result transaction: %h", got);
            return;
        end
        exp = pending_results.pop_front();
        if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"result mismatch: exp pv=%0d val=%h col=%0d row=%0d wb=%0d ",
                          "fin=%0d st=%0d / got pv=%0d val=%h col=%0d row=%0d wb=%0d ",
                          "fin=%0d st=%0d"},
                         exp.pixel_valid, exp.pixel_value, exp.pixel_column,
                         exp.pixel_row, exp.wants_byte, exp.finished, exp.status,
                         got.pixel_valid, got.pixel_value, got.pixel_column,
                         got.pixel_row, got.wants_byte, got.finished, got.status);
        end
    endfunction
endclass

    localparam int LIMIT_CYCLES = 1000000;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    bit          steady;
    int unsigned cycles;
    int unsigned good_items;
    rle_scoreboard sb;

    irbd_in_if  in_if();
    irbd_out_if out_if();

    interleaved_rle_bitmap_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_stream  (in_if),
        .out_stream (out_if)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stall before each transaction, none in steady mode
    initial
    begin
        int unsigned stall;
        result_t got;
        out_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge clk); while (!out_if.valid);
            got.pixel_valid = out_if.pixel_valid;
            got.pixel_value = out_if.pixel_value;
            got.pixel_column = out_if.pixel_column;
            got.pixel_row = out_if.pixel_row;
            got.wants_byte = out_if.wants_byte;
            got.finished = out_if.finished;
            got.status = out_if.status;
            sb.check_result(got);
            @(negedge clk);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(logic [1:0] cmd, logic [7:0] b, logic last, output logic [2:0] st);
        int unsigned gap;
        item_t it;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.command <= cmd;
        in_if.data_byte <= b;
        in_if.last_byte <= last;
        do @(posedge clk); while (!in_if.ready);
        it.command = cmd;
        it.data_byte = b;
        it.last_byte = last;
        st = sb.note_input(it);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic reg_write(logic idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.configure(idx, val);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_size(logic [31:0] w, logic [31:0] h);
        wait_idle();
        reg_write(REG_WIDTH, w);
        @(negedge clk);
        reg_write(REG_HEIGHT, h);
    endtask

    task automatic tick_until_byte();
        logic [2:0] st;
        while (sb.phase != PH_DONE && !sb.wants_byte()) send_item(CMD_TICK, 8'h00, 1'b0, st);
    endtask

    // feeds a stream, inserting ticks as the decoder asks; last flag on the final byte
    task automatic feed_stream(logic [7:0] bytes[$]);
        logic [2:0] st;
        foreach (bytes[i]) begin
            tick_until_byte();
            if (sb.phase == PH_DONE) break;
            send_item(CMD_BYTE, bytes[i], i == bytes.size() - 1, st);
        end
        tick_until_byte();
    endtask

    function automatic logic [7:0] random_header();
        logic [7:0] code;
        code = $urandom_range(0, 255);
        if (code[7:4] < 4'hc)
            code[4:0] = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
        return code;
    endfunction

    task automatic random_item(int unsigned stream_len, output logic [2:0] st);
        logic [7:0] b;
        logic last;
        if (sb.phase == PH_DONE) begin
            if ($urandom_range(0, 7) == 0)
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, st);
            else
                send_item(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), st);
        end else if ($urandom_range(0, 39) == 0) begin
            // noise: any command, any payload
            send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), st);
        end else if ($urandom_range(0, 99) == 0) begin
            send_item(CMD_START, 8'h00, 1'b0, st);
        end else if (!sb.wants_byte()) begin
            send_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), st);
        end else begin
            b = $urandom_range(0, 255);
            last = 1'b0;
            case (sb.phase)
                PH_HEADER:
                begin
                    b = random_header();
                    last = stream_len > 12 && $urandom_range(0, 9) == 0;
                end
                PH_CNT_HI: b = ($urandom_range(0, 15) == 0) ? 8'h01 : 8'h00;
                default: last = $urandom_range(0, 199) == 0;
            endcase
            send_item(CMD_BYTE, b, last, st);
        end
    endtask

    initial
    begin
        logic [2:0] st;
        int unsigned stream_len, n, wsel, hsel;
        logic [31:0] w, h;
        sb = new();
        cycles = 0;
        good_items = 0;
        steady = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.command = CMD_TICK;
        in_if.data_byte = 8'h00;
        in_if.last_byte = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every order, all count forms, normal end
        set_size(16, 16);
        feed_stream('{8'h03, 8'h02, 8'h22, 8'h41, 8'ha5, 8'h60, 8'h00, 8'h5a,
                      8'h81, 8'hff, 8'hc2, 8'h0f, 8'hd1, 8'h33, 8'h96, 8'he1,
                      8'h11, 8'h22, 8'hf0, 8'h00, 8'h00, 8'hf9, 8'hfa, 8'hfd,
                      8'hfe, 8'hf1, 8'h02, 8'h00, 8'hf8, 8'h01, 8'h00, 8'h44,
                      8'h55, 8'hf4, 8'h01, 8'h00, 8'h77, 8'hf2, 8'h01, 8'h00,
                      8'h01, 8'hf3, 8'h01, 8'h00, 8'h99, 8'hf6, 8'h01, 8'h00,
                      8'h21, 8'hf7, 8'h01, 8'h00, 8'h12, 8'h3c, 8'h00, 8'h00});
        // misuse after the end, then an unknown order
        send_item(CMD_TICK, 8'h00, 1'b0, st);
        send_item(CMD_BYTE, 8'hff, 1'b1, st);
        send_item(CMD_BAD, 8'h00, 1'b0, st);
        send_item(CMD_START, 8'h00, 1'b0, st);
        feed_stream('{8'hfb});
        // byte where a tick is due, then a truncated stream
        send_item(CMD_START, 8'h00, 1'b0, st);
        send_item(CMD_BYTE, 8'h01, 1'b0, st);
        send_item(CMD_BYTE, 8'h01, 1'b0, st);
        send_item(CMD_START, 8'h00, 1'b0, st);
        send_item(CMD_BYTE, 8'h80, 1'b1, st);
        send_item(CMD_BAD, 8'h00, 1'b0, st);
        // row overrun on a one-pixel bitmap
        set_size(1, 1);
        feed_stream('{8'h05});

        stream_len = 0;
        n = 0;
        while (good_items < 1000) begin
            if (n % 97 == 96) steady = !steady;
            if (n % 150 == 149) begin
                wsel = $urandom_range(0, 9);
                hsel = $urandom_range(0, 9);
                w = (wsel == 0) ? 0 : (wsel == 1) ? 4096 : (wsel == 2) ? 8191 :
                    $urandom_range(1, 16);
                h = (hsel == 0) ? 0 : (hsel == 1) ? 4096 : (hsel == 2) ? 8191 :
                    $urandom_range(1, 8);
                set_size(w, h);
                stream_len = 0;
            end
            if (sb.phase == PH_DONE) stream_len = 0;
            random_item(stream_len, st);
            stream_len++;
            n++;
            if (st != ST_MISUSE) good_items++;
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

### interleaved_rle_bitmap_decoder.f
src/irbd_pkg.sv
src/irbd_ifs.sv
src/irbd_ram.sv
src/irbd_front.sv
src/irbd_back.sv
src/interleaved_rle_bitmap_decoder.sv
sim/tb_top.sv
